// ===== rtl/tmr_pkg.sv =====
`default_nettype none
// ============================================================================
// tmr_pkg: shared types and constants of the periodic / one-shot timer
// Holds command codes, register indexes, controller state and the
// command / status bundles between the controller and the datapath.
// ============================================================================
package tmr_pkg;

  // Default width of the elapsed count
  localparam int TIME_BITS_DEF = 32;

  // Command codes carried in the action field of an item
  typedef logic [3:0] action_t;
  localparam action_t ACT_TICK     = 4'd0;
  localparam action_t ACT_PAUSE    = 4'd1;
  localparam action_t ACT_PLAY     = 4'd2;
  localparam action_t ACT_STOP     = 4'd3;
  localparam action_t ACT_RESET    = 4'd4;
  localparam action_t ACT_RESTART  = 4'd5;
  localparam action_t ACT_DESTROY  = 4'd6;
  localparam action_t ACT_LOOP_ON  = 4'd7;
  localparam action_t ACT_LOOP_OFF = 4'd8;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TARGET       = 2'd0;
  localparam cfg_idx_t CFG_START_LOOP   = 2'd1;
  localparam cfg_idx_t CFG_START_PAUSED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_PUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;      // apply the accepted item to the timer state
    logic mod_step;  // one restoring-subtract step of the wrap
    logic mod_last;  // final step: write the remainder into elapsed
    logic push;      // load the result register
    logic cfg_we;    // configuration write
  } tmr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_mod;  // the pending tick wraps in loop mode
  } tmr_sts_t;

  // Width of the target register
  function automatic int target_width(input int tb);
    return (tb < 32) ? tb : 32;
  endfunction

  // Width of the exact tick sum: elapsed plus a 31-bit delta, with carry
  function automatic int sum_width(input int tb);
    return ((tb > 31) ? tb : 31) + 1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/periodic_one_shot_timer_unit.sv =====
`default_nettype none
// ============================================================================
// periodic_one_shot_timer_unit: tick-driven one-shot / periodic timer
// Top level joining the controller and the datapath.
// ============================================================================
// Each item is one command (tick, pause, play, stop, reset, restart, destroy,
// loop on, loop off) and yields exactly one result item with the flags, the
// elapsed count and the remaining count. Most commands go from accept straight
// to the push state, which loads the result register once downstream is free. A
// tick that reaches the target in loop mode first wraps the exact sum modulo the
// target on a restoring divider that retires one bit a cycle. Only one item is
// in work at a time; the result register frees the input side while a finished
// result is still waiting downstream. Configuration writes are taken while the
// block is idle. Register 0 sets the target; registers 1 and 2 (start loop /
// start paused) are accepted but not stored, so the timer always comes out of
// reset running and in one-shot mode and those writes leave no mark.
// ============================================================================
module periodic_one_shot_timer_unit #(
  parameter int TIME_BITS = tmr_pkg::TIME_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // command items
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tmr_pkg::action_t   action,
  input  wire logic signed [31:0] delta_ticks,
  // result items
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    fired,
  output logic                    done_res,
  output logic                    halted,
  output logic                    living,
  output logic                    looping,
  output logic [31:0]             elapsed_out,
  output logic [31:0]             remaining_out,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire tmr_pkg::cfg_idx_t  cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import tmr_pkg::*;

  tmr_cmd_t cmd;
  tmr_sts_t sts;

  // Sequence accept, wrap steps and the result hand-off
  tmr_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold timer state, target, modulo unit and the result register
  tmr_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .delta_ticks   (delta_ticks),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fired         (fired),
    .done_res      (done_res),
    .halted        (halted),
    .living        (living),
    .looping       (looping),
    .elapsed_out   (elapsed_out),
    .remaining_out (remaining_out)
  );

endmodule
`default_nettype wire

// ===== rtl/tmr_ctrl.sv =====
`default_nettype none
// ============================================================================
// tmr_ctrl: timer controller
// Sequences accept, the bit-serial wrap and the result hand-off.
// ============================================================================
module tmr_ctrl #(
  parameter int TIME_BITS = tmr_pkg::TIME_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire tmr_pkg::tmr_sts_t sts,
  output tmr_pkg::tmr_cmd_t     cmd
);
  import tmr_pkg::*;

  localparam int SUM_W = sum_width(TIME_BITS);
  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             push;

  assign accept = in_valid && (state == ST_IDLE);
  assign push   = (state == ST_PUSH) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = sts.need_mod ? ST_MOD : ST_PUSH;
        end
      end
      ST_MOD: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != ST_IDLE);
    cfg_ready    = (state == ST_IDLE);
    cmd.exec     = accept;
    cmd.mod_step = (state == ST_MOD);
    cmd.mod_last = (state == ST_MOD) && (cnt == CNT_LAST);
    cmd.push     = push;
    cmd.cfg_we   = cfg_valid && (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MOD) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> !(out_valid && out_stall))
    else $error("result register loaded while a result is held");

  a_wrap_entry: assert property (@(posedge clk) disable iff (rst)
    (accept && sts.need_mod) |=> (state == ST_MOD) && (cnt == '0))
    else $error("wrap did not start after a wrapping tick");

  a_wrap_exit: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_last |=> (state == ST_PUSH))
    else $error("wrap did not hand off to the result stage");

endmodule
`default_nettype wire

// ===== rtl/tmr_dp.sv =====
`default_nettype none
// ============================================================================
// tmr_dp: timer datapath
// Timer state, target register, restoring modulo unit and result register.
// ============================================================================
module tmr_dp #(
  parameter int TIME_BITS = tmr_pkg::TIME_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tmr_pkg::tmr_cmd_t   cmd,
  output tmr_pkg::tmr_sts_t        sts,
  input  wire tmr_pkg::action_t    action,
  input  wire logic signed [31:0]  delta_ticks,
  input  wire tmr_pkg::cfg_idx_t   cfg_index,
  input  wire logic [31:0]         cfg_data,
  output logic                     fired,
  output logic                     done_res,
  output logic                     halted,
  output logic                     living,
  output logic                     looping,
  output logic [31:0]              elapsed_out,
  output logic [31:0]              remaining_out
);
  import tmr_pkg::*;

  localparam int TW    = target_width(TIME_BITS);
  localparam int SUM_W = sum_width(TIME_BITS);

  // Timer state
  logic [TIME_BITS-1:0] elapsed, elapsed_next;
  logic                 fired_f, fired_next;
  logic                 done_f, done_next;
  logic                 halted_f, halted_next;
  logic                 living_f, living_next;
  logic                 loop_f, loop_next;
  logic [TW-1:0]        target;

  // Modulo unit
  logic [SUM_W-1:0]     dividend;
  logic [TW-1:0]        rem;
  logic [TW:0]          shifted;
  logic [TW:0]          diff;
  logic [TW-1:0]        trial;

  logic [30:0]          d_pos;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] target_e;
  logic                 tgt_zero;
  logic                 wraps;
  logic                 tick_live;
  logic [TIME_BITS-1:0] remain_full;

  assign d_pos     = delta_ticks[31] ? '0 : delta_ticks[30:0];
  assign sum       = SUM_W'(elapsed) + SUM_W'(d_pos);
  assign target_e  = TIME_BITS'(target);
  assign tgt_zero  = (target == '0);
  assign wraps     = (sum >= SUM_W'(target));
  assign tick_live = living_f && !halted_f;

  assign sts.need_mod = (action == ACT_TICK) && tick_live && !tgt_zero && wraps && loop_f;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem, dividend[SUM_W-1]};
  assign diff    = shifted - {1'b0, target};
  assign trial   = (shifted >= {1'b0, target}) ? diff[TW-1:0] : shifted[TW-1:0];

  assign remain_full = (target_e > elapsed) ? (target_e - elapsed) : '0;

  always_comb begin
    elapsed_next = elapsed;
    fired_next   = fired_f;
    done_next    = done_f;
    halted_next  = halted_f;
    living_next  = living_f;
    loop_next    = loop_f;
    if (cmd.exec) begin
      unique case (action)
        ACT_TICK: begin
          fired_next = 1'b0;
          if (tick_live) begin
            if (tgt_zero) begin
              fired_next = 1'b1;
              if (loop_f) begin
                elapsed_next = '0;
              end else begin
                done_next   = 1'b1;
                halted_next = 1'b1;
              end
            end else if (!wraps) begin
              elapsed_next = TIME_BITS'(sum);
            end else begin
              fired_next = 1'b1;
              if (!loop_f) begin
                elapsed_next = target_e;
                done_next    = 1'b1;
                halted_next  = 1'b1;
              end
            end
          end
        end
        ACT_PAUSE: halted_next = 1'b1;
        ACT_PLAY: begin
          halted_next = 1'b0;
          if (!loop_f && done_f && (elapsed >= target_e)) begin
            elapsed_next = '0;
            fired_next   = 1'b0;
            done_next    = 1'b0;
          end
        end
        ACT_STOP: begin
          halted_next  = 1'b1;
          elapsed_next = '0;
          fired_next   = 1'b0;
          done_next    = 1'b0;
        end
        ACT_RESET: begin
          elapsed_next = '0;
          fired_next   = 1'b0;
          done_next    = 1'b0;
        end
        ACT_RESTART: begin
          halted_next  = 1'b0;
          elapsed_next = '0;
          fired_next   = 1'b0;
          done_next    = 1'b0;
        end
        ACT_DESTROY: living_next = 1'b0;
        ACT_LOOP_ON: begin
          loop_next = 1'b1;
          done_next = 1'b0;
        end
        ACT_LOOP_OFF: loop_next = 1'b0;
        default: ;
      endcase
    end
    if (cmd.mod_last) begin
      elapsed_next = TIME_BITS'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      fired_f  <= 1'b0;
      done_f   <= 1'b0;
      halted_f <= 1'b0;
      living_f <= 1'b1;
      loop_f   <= 1'b0;
      target   <= '0;
    end else begin
      elapsed  <= elapsed_next;
      fired_f  <= fired_next;
      done_f   <= done_next;
      halted_f <= halted_next;
      living_f <= living_next;
      loop_f   <= loop_next;
      if (cmd.cfg_we && (cfg_index == CFG_TARGET)) begin
        target <= cfg_data[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      dividend <= sum;
      rem      <= '0;
    end else if (cmd.mod_step) begin
      dividend <= dividend << 1;
      rem      <= trial;
    end
    if (cmd.push) begin
      fired         <= fired_f;
      done_res      <= done_f;
      halted        <= halted_f;
      living        <= living_f;
      looping       <= loop_f;
      elapsed_out   <= 32'(elapsed);
      remaining_out <= 32'(remain_full);
    end
  end

  a_rem_below_target: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_step |-> (rem < target))
    else $error("partial remainder not below target");

  a_wrap_fires: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && sts.need_mod) |=> fired_f && !done_f)
    else $error("wrapping tick did not fire");

  a_oneshot_clamp: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (action == ACT_TICK) && tick_live && !loop_f && !tgt_zero && wraps)
      |=> (elapsed == target_e) && halted_f && done_f)
    else $error("one-shot completion did not clamp and halt");

endmodule
`default_nettype wire

// ===== test/tmr_status_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tmr_status_checker: command-by-command status predictor for the timer
// Watches the command, result and register-write channels, keeps a shadow
// copy of the timer state, and compares each result item with the status
// that the oldest outstanding command should have produced.
// ============================================================================
module tmr_status_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire tmr_pkg::action_t   action,
  input  wire logic signed [31:0] delta_ticks,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               fired,
  input  wire logic               done_res,
  input  wire logic               halted,
  input  wire logic               living,
  input  wire logic               looping,
  input  wire logic [31:0]        elapsed_out,
  input  wire logic [31:0]        remaining_out,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire tmr_pkg::cfg_idx_t  cfg_index,
  input  wire logic [31:0]        cfg_data,
  output int                      mismatches,
  output int                      pending,
  output int                      checked,
  output int                      fires
);
  import tmr_pkg::*;

  typedef struct {
    logic        fired;
    logic        done;
    logic        halted;
    logic        living;
    logic        looping;
    logic [31:0] elapsed;
    logic [31:0] remaining;
  } timer_status_t;

  // shadow registers and timer state
  logic [31:0] target_q;
  logic        start_loop_q, start_paused_q;
  logic [31:0] elapsed_q;
  logic        fired_q, done_q, halted_q, living_q, loop_q;

  timer_status_t awaited_status[$];

  function automatic void clear_run();
    elapsed_q = '0;
    fired_q   = 1'b0;
    done_q    = 1'b0;
  endfunction

  function automatic void resume();
    halted_q = 1'b0;
    if (!loop_q && done_q && elapsed_q >= target_q) clear_run();
  endfunction

  function automatic void advance(input logic signed [31:0] raw);
    logic [31:0] d, em, dm;
    logic [32:0] sum, s;
    fired_q = 1'b0;
    if (!living_q || halted_q) return;
    if (target_q == '0) begin
      fired_q = 1'b1;
      if (loop_q) begin
        elapsed_q = '0;
      end else begin
        done_q   = 1'b1;
        halted_q = 1'b1;
      end
      return;
    end
    // negative deltas count as no time at all
    d   = raw[31] ? '0 : {1'b0, raw[30:0]};
    sum = {1'b0, elapsed_q} + {1'b0, d};
    if (!sum[32] && sum[31:0] < target_q) begin
      elapsed_q = sum[31:0];
      return;
    end
    fired_q = 1'b1;
    if (loop_q) begin
      em = elapsed_q % target_q;
      dm = d % target_q;
      s  = {1'b0, em} + {1'b0, dm};
      if (s >= {1'b0, target_q}) s = s - {1'b0, target_q};
      elapsed_q = s[31:0];
    end else begin
      elapsed_q = target_q;
      done_q    = 1'b1;
      halted_q  = 1'b1;
    end
  endfunction

  function automatic timer_status_t next_status(input action_t act,
                                                input logic signed [31:0] delta);
    timer_status_t st;
    case (act)
      ACT_TICK:     advance(delta);
      ACT_PAUSE:    halted_q = 1'b1;
      ACT_PLAY:     resume();
      ACT_STOP: begin
        halted_q = 1'b1;
        clear_run();
      end
      ACT_RESET:    clear_run();
      ACT_RESTART: begin
        clear_run();
        resume();
      end
      ACT_DESTROY:  living_q = 1'b0;
      ACT_LOOP_ON: begin
        loop_q = 1'b1;
        done_q = 1'b0;
      end
      ACT_LOOP_OFF: loop_q = 1'b0;
      default: ;
    endcase
    st.fired     = fired_q;
    st.done      = done_q;
    st.halted    = halted_q;
    st.living    = living_q;
    st.looping   = loop_q;
    st.elapsed   = elapsed_q;
    st.remaining = (target_q > elapsed_q) ? target_q - elapsed_q : '0;
    return st;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    timer_status_t want, predicted;
    if (rst) begin
      // registers clear first, then the state loads from them
      target_q       = '0;
      start_loop_q   = 1'b0;
      start_paused_q = 1'b0;
      clear_run();
      halted_q = start_paused_q;
      living_q = 1'b1;
      loop_q   = start_loop_q;
      awaited_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET:       target_q = cfg_data;
          CFG_START_LOOP:   start_loop_q = cfg_data[0];
          CFG_START_PAUSED: start_paused_q = cfg_data[0];
          default: ;
        endcase
      end
      // retire the result first: it always belongs to an earlier command
      if (out_valid && !out_stall) begin
        if (awaited_status.size() == 0) begin
          $error("result item with no command outstanding");
          mismatches++;
        end else begin
          want = awaited_status.pop_front();
          check_field("fired", 32'(want.fired), 32'(fired));
          check_field("done_res", 32'(want.done), 32'(done_res));
          check_field("halted", 32'(want.halted), 32'(halted));
          check_field("living", 32'(want.living), 32'(living));
          check_field("looping", 32'(want.looping), 32'(looping));
          check_field("elapsed_out", want.elapsed, elapsed_out);
          check_field("remaining_out", want.remaining, remaining_out);
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        predicted = next_status(action, delta_ticks);
        awaited_status.push_back(predicted);
        if (predicted.fired) fires++;
      end
    end
    pending <= awaited_status.size();
  end

endmodule

// ===== test/tb_periodic_one_shot_timer_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_periodic_one_shot_timer_unit: regression bench for the tick timer
// Drives directed and random command items through the timer under several
// target settings, with random gaps and back-pressure, and lets the status
// checker compare every result item against its own prediction.
// ============================================================================
module tb_periodic_one_shot_timer_unit;
  import tmr_pkg::*;

  localparam int      IDLE_PCT    = 24;   // percent of cycles a side idles
  localparam int      TAIL_CYCLES = 40;   // longer than the slowest wrap
  localparam action_t ACT_LAST    = ACT_LOOP_OFF;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  action_t            action = ACT_TICK;
  logic signed [31:0] delta_ticks = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               fired, done_res, halted, living, looping;
  logic [31:0]        elapsed_out, remaining_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = CFG_TARGET;
  logic [31:0]        cfg_data = '0;

  // set during one phase to give a long stretch with no idling on either side
  logic quiet = 1'b0;

  int sent = 0;
  int settings = 0;
  int mismatches, pending, checked, fires;

  periodic_one_shot_timer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .delta_ticks  (delta_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fired        (fired),
    .done_res     (done_res),
    .halted       (halted),
    .living       (living),
    .looping      (looping),
    .elapsed_out  (elapsed_out),
    .remaining_out(remaining_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  tmr_status_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .delta_ticks  (delta_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fired        (fired),
    .done_res     (done_res),
    .halted       (halted),
    .living       (living),
    .looping      (looping),
    .elapsed_out  (elapsed_out),
    .remaining_out(remaining_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .checked      (checked),
    .fires        (fires)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random, except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Offer one command item and hold it until the block takes it. Valid is
  // left high afterwards so that back-to-back items never see a low pulse;
  // it only drops when a gap is chosen or the phase drains.
  task automatic send_cmd(input action_t act, input logic signed [31:0] d);
    bit taken;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    delta_ticks <= d;
    // sample the stall mid-cycle, away from the edge where it may move
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  // Drop valid and wait until every outstanding command has its result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Only call with the block idle. The start flags load at reset alone, so
  // writing them here must leave the running state untouched.
  task automatic set_registers(input logic [31:0] tgt, input bit lp, input bit ps);
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_START_LOOP, {31'd0, lp});
    write_reg(CFG_START_PAUSED, {31'd0, ps});
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Mostly ticks, with enough play and restart to keep one-shot runs moving.
  // Destroy is never picked: it is permanent and kept for the last phase.
  function automatic action_t pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 55) return ACT_TICK;
    if (r < 60) return ACT_PAUSE;
    if (r < 70) return ACT_PLAY;
    if (r < 74) return ACT_STOP;
    if (r < 78) return ACT_RESET;
    if (r < 84) return ACT_RESTART;
    if (r < 89) return ACT_LOOP_ON;
    if (r < 94) return ACT_LOOP_OFF;
    return action_t'($urandom_range(15, ACT_LAST + 1));
  endfunction

  // Scale deltas to the target so that runs both accumulate and overshoot.
  function automatic logic signed [31:0] pick_delta(input logic [31:0] tgt);
    int          r;
    logic [31:0] lim;
    r = $urandom_range(99);
    if (r < 10) return {1'b1, 31'($urandom)};
    if (r < 15) return 32'sh7FFF_FFFF;
    if (r < 25) return $urandom;
    if (r < 32) return '0;
    if (tgt > 32'h3FFF_FFFF) lim = 32'h7FFF_FFFF;
    else if (tgt < 2)        lim = 32'd3;
    else                     lim = tgt * 2;
    return $urandom_range(lim, 0);
  endfunction

  task automatic run_phase(input logic [31:0] tgt, input int n, input bit hush);
    drain();
    set_registers(tgt, 1'($urandom_range(1)), 1'($urandom_range(1)));
    quiet <= hush;
    repeat (n) send_cmd(pick_action(), pick_delta(tgt));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- one-shot basics at a target of ten ---
    set_registers(32'd10, 1'b1, 1'b1);
    send_cmd(ACT_TICK, 32'sd3);
    send_cmd(ACT_TICK, -32'sd5);             // negative delta adds nothing
    send_cmd(ACT_TICK, 32'sh8000_0000);      // most negative delta
    send_cmd(ACT_PAUSE, '0);
    send_cmd(ACT_TICK, 32'sd4);              // ignored while paused
    send_cmd(ACT_PLAY, '0);
    send_cmd(ACT_TICK, 32'sd20);             // overshoot clamps, done, halts
    send_cmd(ACT_PLAY, '0);                  // replay clears the finished run
    send_cmd(ACT_LOOP_ON, '0);
    send_cmd(ACT_TICK, 32'sd7);
    send_cmd(ACT_TICK, 32'sh7FFF_FFFF);      // loop wrap of a huge delta
    send_cmd(ACT_STOP, '0);
    send_cmd(ACT_PLAY, '0);
    send_cmd(ACT_RESET, '0);
    send_cmd(ACT_RESTART, '0);
    send_cmd(ACT_LOOP_OFF, '0);
    send_cmd(action_t'(ACT_LAST + 1), '0);   // unknown codes leave state alone
    send_cmd(action_t'(4'hF), 32'sh7FFF_FFFF);

    // --- zero target fires on every effective tick ---
    drain();
    set_registers(32'd0, 1'b0, 1'b1);
    send_cmd(ACT_TICK, 32'sd1);
    send_cmd(ACT_PLAY, '0);
    send_cmd(ACT_LOOP_ON, '0);
    send_cmd(ACT_TICK, -32'sd1);

    // --- full-range target: carry out of the tick sum, then wrap ---
    drain();
    set_registers(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_cmd(ACT_TICK, 32'sh7FFF_FFFF);
    send_cmd(ACT_TICK, 32'sh7FFF_FFFF);
    send_cmd(ACT_TICK, 32'sh7FFF_FFFF);

    // --- lower the target below the elapsed count, then wrap from above ---
    drain();
    set_registers(32'd3, 1'b0, 1'b0);
    send_cmd(ACT_TICK, '0);

    // --- random phases, one register setting each ---
    run_phase(32'd0, 62, 1'b0);
    run_phase(32'd1, 62, 1'b0);
    run_phase($urandom_range(12, 2), 62, 1'b0);
    run_phase($urandom_range(5000, 100), 62, 1'b1);
    run_phase(32'hFFFF_FFFF, 62, 1'b0);
    run_phase($urandom, 62, 1'b0);
    run_phase($urandom_range(40, 2), 62, 1'b0);   // often starts above target
    run_phase(32'h8000_0000, 62, 1'b0);

    // --- kill the timer last: ticks stop, other commands still act ---
    drain();
    set_registers($urandom_range(30, 5), 1'($urandom_range(1)), 1'($urandom_range(1)));
    quiet <= 1'b0;
    send_cmd(ACT_DESTROY, $urandom);
    repeat (24) send_cmd(pick_action(), pick_delta(32'd20));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d commands across %0d register settings", sent, settings);
    $display("checked %0d results, %0d of them firing", checked, fires);
    if (mismatches == 0 && pending == 0) begin
      $display("periodic_one_shot_timer_unit regression: pass");
    end else begin
      $display("periodic_one_shot_timer_unit regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("periodic_one_shot_timer_unit regression: fail");
    $finish;
  end

endmodule
